@@ hdl/cds_pkg.sv @@
// cds_pkg: shared types, codes and constants of the cumulative distribution sampler
// used by the controller, the datapath, the top level and the port checker
`default_nettype none

package cds_pkg;

  localparam int MAX_QUBITS_DEF = 10;
  localparam int CFG_W = 17;
  localparam int QC_W = 5;
  localparam int MUL_STEPS = 3;
  localparam logic [QC_W-1:0] QUBIT_COUNT_RST = 5'd10;
  localparam logic [CFG_W-1:0] OUTCOME_LIMIT_RST = 17'd1024;

  typedef enum logic [1:0] {
    OP_START,
    OP_LOAD,
    OP_SHOT,
    OP_READ
  } op_t;

  typedef enum logic {
    REG_QUBIT_COUNT,
    REG_OUTCOME_LIMIT
  } reg_idx_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] amp_re;
    logic signed [15:0] amp_im;
    logic [15:0]        rnd;
    logic [15:0]        read_index;
  } in_word_t;

  typedef struct packed {
    logic [15:0] outcome;
    logic [31:0] count;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_MUL,
    ST_LOAD_ACC,
    ST_TOT_RD,
    ST_TOT_SET,
    ST_MUL,
    ST_SRCH,
    ST_SCALE,
    ST_CMP,
    ST_CNT_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic clear_start;
    logic clear_step;
    logic load_mul;
    logic load_acc;
    logic tot_rd;
    logic tot_set;
    logic mul_step;
    logic srch_rd;
    logic srch_scale;
    logic srch_cmp;
    logic cnt_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mul_last;
    logic search_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/cds_ctrl.sv @@
// cds_ctrl: sequencing state machine of the sampler
// depends on cds_pkg; drives the command word of cds_dpath
`default_nettype none

module cds_ctrl
  import cds_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire op_t  op,
  input  wire sts_t sts,
  output logic      in_ready,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_START: state_next = ST_CLEAR;
            OP_LOAD:  state_next = ST_LOAD_MUL;
            OP_SHOT:  state_next = ST_TOT_RD;
            OP_READ:  state_next = ST_CNT_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD_MUL: state_next = ST_LOAD_ACC;
      ST_LOAD_ACC: state_next = ST_IDLE;
      ST_TOT_RD:   state_next = ST_TOT_SET;
      ST_TOT_SET:  state_next = ST_MUL;
      ST_MUL: begin
        if (sts.mul_last) begin
          state_next = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (sts.search_done) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE:  state_next = ST_CMP;
      ST_CMP:    state_next = ST_SRCH;
      ST_CNT_RD: state_next = ST_OUT;
      ST_OUT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        cmd.clear_start = in_valid && (op == OP_START);
      end
      ST_LOAD_MUL: cmd.load_mul = 1'b1;
      ST_LOAD_ACC: cmd.load_acc = 1'b1;
      ST_TOT_RD:   cmd.tot_rd = 1'b1;
      ST_TOT_SET:  cmd.tot_set = 1'b1;
      ST_MUL:      cmd.mul_step = 1'b1;
      ST_SRCH: begin
        cmd.cnt_rd = sts.search_done;
        cmd.srch_rd = !sts.search_done;
      end
      ST_SCALE:  cmd.srch_scale = 1'b1;
      ST_CMP:    cmd.srch_cmp = 1'b1;
      ST_CNT_RD: cmd.cnt_rd = 1'b1;
      ST_OUT:    cmd.out_load = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/cds_dpath.sv @@
// cds_dpath: tables, running total, search registers and output word register
// depends on cds_pkg; steered by the command word of cds_ctrl
`default_nettype none

module cds_dpath
  import cds_pkg::*;
#(
  parameter int MAX_QUBITS = MAX_QUBITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire reg_idx_t         cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire in_word_t         in_word,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  wire cmd_t             cmd,
  output sts_t                  sts
);

  localparam int AW = MAX_QUBITS;
  localparam int DEPTH = 1 << MAX_QUBITS;

  logic [QC_W-1:0]  qubit_count;
  logic [CFG_W-1:0] outcome_limit;

  logic [47:0] cum_mem [DEPTH];
  logic [31:0] cnt_mem [DEPTH];
  logic [47:0] cum_rdata;
  logic [31:0] cnt_rdata;

  in_word_t    item;
  logic [47:0] running_total;
  logic [AW:0] load_pointer;
  logic [AW-1:0] clr_addr;
  logic [30:0] sq_re;
  logic [30:0] sq_im;
  logic [47:0] total;
  logic        total_zero;
  logic [63:0] prod;
  logic [1:0]  mul_cnt;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [AW-1:0] mid;
  logic        use_mem;
  logic [63:0] scaled;

  // search range
  logic [QC_W-1:0]  q_eff;
  logic [AW:0]      dim_pow;
  logic [CFG_W-1:0] lim_eff;
  logic [AW:0]      dim;
  logic [AW:0]      dim_m1_full;
  logic [AW-1:0]    dim_m1;

  always_comb begin
    q_eff = (qubit_count > QC_W'(MAX_QUBITS)) ? QC_W'(MAX_QUBITS) : qubit_count;
    dim_pow = {{AW{1'b0}}, 1'b1} << q_eff;
    lim_eff = (outcome_limit == '0) ? CFG_W'(1) : outcome_limit;
    dim = (lim_eff < CFG_W'(dim_pow)) ? lim_eff[AW:0] : dim_pow;
    dim_m1_full = dim - {{AW{1'b0}}, 1'b1};
    dim_m1 = dim_m1_full[AW-1:0];
  end

  logic signed [31:0] re_sq;
  logic signed [31:0] im_sq;
  logic [31:0] p_sum;
  logic [47:0] entry;
  logic [AW-1:0] mid_comb;
  logic [AW-1:0] hl_diff;
  logic [15:0] chunk;
  logic [31:0] pp;
  logic [63:0] pp_shift;
  logic        go_right;
  logic        in_range;
  logic [31:0] cnt_inc;
  logic        is_shot;

  assign re_sq = item.amp_re * item.amp_re;
  assign im_sq = item.amp_im * item.amp_im;
  assign p_sum = {1'b0, sq_re} + {1'b0, sq_im};
  assign hl_diff = hi - lo;
  assign mid_comb = lo + (hl_diff >> 1);
  assign entry = use_mem ? cum_rdata : running_total;
  assign go_right = total_zero ? (item.rnd != 16'd0) : (scaled < prod);
  assign in_range = {1'b0, item.read_index} < 17'(DEPTH);
  assign cnt_inc = (&cnt_rdata) ? cnt_rdata : cnt_rdata + 32'd1;
  assign is_shot = (item.op == OP_SHOT);

  always_comb begin
    case (mul_cnt)
      2'd0:    chunk = total[15:0];
      2'd1:    chunk = total[31:16];
      default: chunk = total[47:32];
    endcase
    pp = item.rnd * chunk;
    case (mul_cnt)
      2'd0:    pp_shift = {32'd0, pp};
      2'd1:    pp_shift = {16'd0, pp, 16'd0};
      default: pp_shift = {pp, 32'd0};
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      qubit_count <= QUBIT_COUNT_RST;
      outcome_limit <= OUTCOME_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUBIT_COUNT:   qubit_count <= cfg_data[QC_W-1:0];
        REG_OUTCOME_LIMIT: outcome_limit <= cfg_data;
        default:           qubit_count <= qubit_count;
      endcase
    end
  end

  // control state of the tables
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_start) begin
      running_total <= '0;
      load_pointer <= '0;
      clr_addr <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.load_acc && (load_pointer < (AW+1)'(DEPTH))) begin
        running_total <= running_total + {16'd0, p_sum};
        load_pointer <= load_pointer + 1'b1;
      end
    end
  end

  // cumulative table
  always_ff @(posedge clk) begin
    if (cmd.load_acc && (load_pointer < (AW+1)'(DEPTH))) begin
      cum_mem[load_pointer[AW-1:0]] <= running_total + {16'd0, p_sum};
    end
    if (cmd.tot_rd) begin
      cum_rdata <= cum_mem[dim_m1];
    end else if (cmd.srch_rd) begin
      cum_rdata <= cum_mem[mid_comb];
    end
  end

  // hit counters
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      cnt_mem[clr_addr] <= 32'd0;
    end else if (cmd.out_load && is_shot) begin
      cnt_mem[lo] <= cnt_inc;
    end
    if (cmd.cnt_rd) begin
      cnt_rdata <= cnt_mem[is_shot ? lo : item.read_index[AW-1:0]];
    end
  end

  // item and search payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_word;
    end
    if (cmd.load_mul) begin
      sq_re <= re_sq[30:0];
      sq_im <= im_sq[30:0];
    end
    if (cmd.tot_rd) begin
      lo <= '0;
      hi <= dim_m1;
    end
    if (cmd.tot_set) begin
      total <= (load_pointer >= dim) ? cum_rdata : running_total;
      total_zero <= (load_pointer >= dim) ? (cum_rdata == '0) : (running_total == '0);
      prod <= '0;
      mul_cnt <= '0;
    end
    if (cmd.mul_step) begin
      prod <= prod + pp_shift;
      mul_cnt <= mul_cnt + 2'd1;
    end
    if (cmd.srch_rd) begin
      mid <= mid_comb;
      use_mem <= {1'b0, mid_comb} < load_pointer;
    end
    if (cmd.srch_scale) begin
      scaled <= {entry, 16'd0} - {16'd0, entry};
    end
    if (cmd.srch_cmp) begin
      if (go_right) begin
        lo <= mid + 1'b1;
      end else begin
        hi <= mid;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (is_shot) begin
        out_word.outcome <= 16'(lo);
        out_word.count <= cnt_inc;
      end else begin
        out_word.outcome <= item.read_index;
        out_word.count <= in_range ? cnt_rdata : 32'd0;
      end
    end
  end

  assign sts.clear_last = &clr_addr;
  assign sts.mul_last = (mul_cnt == 2'(MUL_STEPS - 1));
  assign sts.search_done = (lo == hi);
  assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ hdl/cumulative_distribution_sampler.sv @@
// shot: one table read for the total, then one memory read per level of the binary search
// load: squaring, then accumulation; read: counter read, then result load; start: clearing pass over
// all 2^MAX_QUBITS hit counters; one word in flight at a time; a finished result may wait in the
// output register while the next word is taken; shot throughput is set by the binary search loop
// over the cumulative table unless the output register stalls; reset (synchronous, active high)
// restores the registers and runs the same clearing pass with in_ready low before taking a word
`default_nettype none

module cumulative_distribution_sampler
  import cds_pkg::*;
#(
  parameter int MAX_QUBITS = MAX_QUBITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire reg_idx_t         cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_word_t         in_word,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_word_t             out_word
);

  cmd_t cmd;
  sts_t sts;

  cds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (in_word.op),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  cds_dpath #(
    .MAX_QUBITS (MAX_QUBITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

@@ hdl/cds_check.sv @@
// cds_check: port-level checks of the sampler, bound to the top level
// depends on cds_pkg
`default_nettype none

module cds_check
  import cds_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_word_t  in_word,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_word
);

  // clearing pass follows reset
  a_reset_clear : assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // one word at a time
  a_one_item : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word taken while previous one in work");

  // start: checks in_ready low at one point of the clearing pass that follows a start word
  a_start_clear : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_word.op == OP_START)) |=> ##1 !in_ready)
    else $error("start word did not clear counters");

  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("result word dropped or changed while stalled");

  a_out_drop : assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> ($past(out_ready) || $past(rst)))
    else $error("result word withdrawn without handshake");

endmodule

bind cumulative_distribution_sampler cds_check u_cds_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
